// ----- src/fsdm_pkg.sv -----
// Shared types for the floored signed divide and modulo unit.
package fsdm_pkg;

    localparam int FIELD_W = 64;

    typedef struct packed {
        logic signed [FIELD_W-1:0] dividend;
        logic signed [FIELD_W-1:0] divisor;
    } t_div_in;

    typedef struct packed {
        logic signed [FIELD_W-1:0] quotient;
        logic signed [FIELD_W-1:0] remainder;
        logic                      div_by_zero;
        logic                      overflow;
    } t_div_out;

    // Side information that travels with each transaction down the cell chain.
    typedef struct packed {
        logic valid;
        logic aneg;
        logic bneg;
        logic dz;
        logic ov;
    } t_fsdm_ctl;

endpackage

// ----- src/fsdm_prep.sv -----
// Input stage: operand magnitudes, signs and special-case flags.
module fsdm_prep #(
    parameter int W = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [W-1:0]         i_a,
    input  logic [W-1:0]         i_b,
    output fsdm_pkg::t_fsdm_ctl  o_ctl,
    output logic [W-1:0]         o_ua,
    output logic [W-1:0]         o_ub
);

    localparam logic [W-1:0] SIGN_BIT = {1'b1, {(W-1){1'b0}}};

    fsdm_pkg::t_fsdm_ctl r_ctl, n_ctl;
    logic [W-1:0]        r_ua, n_ua;
    logic [W-1:0]        r_ub, n_ub;

    always_comb begin
        n_ctl.valid = i_valid;
        n_ctl.aneg  = i_a[W-1];
        n_ctl.bneg  = i_b[W-1];
        n_ctl.dz    = (i_b == '0);
        n_ctl.ov    = (i_a == SIGN_BIT) && (i_b == '1);
        n_ua        = i_a[W-1] ? (W'(0) - i_a) : i_a;
        n_ub        = i_b[W-1] ? (W'(0) - i_b) : i_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ua <= n_ua;
        r_ub <= n_ub;
    end

    assign o_ctl = r_ctl;
    assign o_ua  = r_ua;
    assign o_ub  = r_ub;

endmodule

// ----- src/fsdm_cell.sv -----
// One restoring-division step: produces one quotient bit per transaction.
module fsdm_cell #(
    parameter int W = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fsdm_pkg::t_fsdm_ctl  i_ctl,
    input  logic [W-1:0]         i_rem,
    input  logic [W-1:0]         i_quo,
    input  logic [W-1:0]         i_dvs,
    output fsdm_pkg::t_fsdm_ctl  o_ctl,
    output logic [W-1:0]         o_rem,
    output logic [W-1:0]         o_quo,
    output logic [W-1:0]         o_dvs
);

    fsdm_pkg::t_fsdm_ctl r_ctl;
    logic [W-1:0]        r_rem, n_rem;
    logic [W-1:0]        r_quo, n_quo;
    logic [W-1:0]        r_dvs;
    logic [W:0]          trial;
    logic [W:0]          diff;
    logic                take;

    // The quotient register doubles as the dividend shifter: its top bit feeds
    // the partial remainder while the new quotient bit enters at the bottom.
    always_comb begin
        trial = {i_rem, i_quo[W-1]};
        diff  = trial - {1'b0, i_dvs};
        take  = !diff[W];
        n_rem = take ? diff[W-1:0] : trial[W-1:0];
        n_quo = {i_quo[W-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= i_dvs;
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_quo = r_quo;
    assign o_dvs = r_dvs;

    // Except on divide by zero, the partial remainder never reaches the divisor magnitude.
    a_rem_below_dvs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl.valid && !r_ctl.dz) |-> (r_rem < r_dvs))
        else $error("partial remainder not below divisor");

endmodule

// ----- src/fsdm_fix.sv -----
// Output stage: floored sign correction and the registered result.
module fsdm_fix #(
    parameter int W = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fsdm_pkg::t_fsdm_ctl  i_ctl,
    input  logic [W-1:0]         i_tq,
    input  logic [W-1:0]         i_tr,
    input  logic [W-1:0]         i_ub,
    output logic                 o_valid,
    output fsdm_pkg::t_div_out   o_res
);

    logic                r_valid;
    fsdm_pkg::t_div_out  r_res, n_res;
    logic signed [W-1:0] q;
    logic signed [W-1:0] r;
    logic                tr_nz;

    always_comb begin
        tr_nz = (i_tr != '0);
        if (i_ctl.dz) begin
            // Divisor zero: the shifted-through remainder is the dividend magnitude.
            q = '0;
            r = i_ctl.aneg ? (W'(0) - i_tr) : i_tr;
        end else if (i_ctl.aneg == i_ctl.bneg) begin
            q = i_tq;
            r = i_ctl.aneg ? (W'(0) - i_tr) : i_tr;
        end else if (tr_nz) begin
            // Round the magnitude up and negate: -(tq + 1) is simply ~tq.
            q = ~i_tq;
            r = i_ctl.bneg ? (i_tr - i_ub) : (i_ub - i_tr);
        end else begin
            q = W'(0) - i_tq;
            r = '0;
        end
        n_res.quotient    = fsdm_pkg::FIELD_W'(q);
        n_res.remainder   = fsdm_pkg::FIELD_W'(r);
        n_res.div_by_zero = i_ctl.dz;
        n_res.overflow    = i_ctl.ov;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ----- src/floored_signed_divide_modulo_unit.sv -----
// Top level of the pipelined floored signed divide and modulo unit.
//
//  channel   ports                    direction  transaction
//  command   start, busy, i_cmd       in         start high while busy low
//  result    o_done, o_res            out        o_done high for one cycle
//
// The pipeline has one operand stage, a chain of DATA_WIDTH
// restoring-division cells producing one quotient bit each, and one output stage.
// A new command is taken every cycle; busy is always low.
// Reset is synchronous and clears only the control fields along the chain.
// The receiver cannot stall, so nothing in the chain ever holds.
module floored_signed_divide_modulo_unit #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  fsdm_pkg::t_div_in    i_cmd,
    output logic                 o_done,
    output fsdm_pkg::t_div_out   o_res
);

    localparam int W   = DATA_WIDTH;
    localparam int LAT = DATA_WIDTH + 2;

    fsdm_pkg::t_fsdm_ctl ctl_chain [0:W];
    logic [W-1:0]        rem_chain [0:W];
    logic [W-1:0]        quo_chain [0:W];
    logic [W-1:0]        dvs_chain [0:W];

    assign busy         = 1'b0;
    assign rem_chain[0] = '0;

    fsdm_prep #(.W(W)) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_a     (i_cmd.dividend[W-1:0]),
        .i_b     (i_cmd.divisor[W-1:0]),
        .o_ctl   (ctl_chain[0]),
        .o_ua    (quo_chain[0]),
        .o_ub    (dvs_chain[0])
    );

    for (genvar g = 0; g < W; g++) begin : g_cell
        fsdm_cell #(.W(W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl_chain[g]),
            .i_rem   (rem_chain[g]),
            .i_quo   (quo_chain[g]),
            .i_dvs   (dvs_chain[g]),
            .o_ctl   (ctl_chain[g+1]),
            .o_rem   (rem_chain[g+1]),
            .o_quo   (quo_chain[g+1]),
            .o_dvs   (dvs_chain[g+1])
        );
    end

    fsdm_fix #(.W(W)) u_fix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_chain[W]),
        .i_tq    (quo_chain[W]),
        .i_tr    (rem_chain[W]),
        .i_ub    (dvs_chain[W]),
        .o_valid (o_done),
        .o_res   (o_res)
    );

    a_done_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, LAT))
        else $error("result without a matching command");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_res.div_by_zero && o_res.overflow))
        else $error("both exception flags set");

    a_dz_quotient_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.div_by_zero) |-> (o_res.quotient == '0))
        else $error("nonzero quotient on divide by zero");

    a_ov_remainder_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.overflow) |-> (o_res.remainder == '0))
        else $error("nonzero remainder on overflow");

endmodule
